FILE: rtl/core/jls_pkg.sv
// ----------------------------------------------------------------------------
// jls_pkg: shared types and constants of the jacobi linear solver
// Field widths, register indexes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package jls_pkg;

   localparam int MaxUnknownsDefault  = 8;
   localparam int FractionBitsDefault = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_UNKNOWNS  = 2'd0;
   localparam logic [1:0] CSR_ITER_LIM  = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_CONVERGED = 2'd0;
   localparam logic [1:0] ST_LIMIT     = 2'd1;
   localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

   // request actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SOLVE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [2:0]        row;
      logic [3:0]        column;
      logic signed [31:0] coefficient;
   } req_type;

   typedef struct packed {
      logic [2:0]         unknown_index;
      logic signed [31:0] solution;
      logic [1:0]         status;
      logic [15:0]        sweeps_done;
      logic               last;
   } rsp_type;

endpackage

FILE: rtl/core/jls_stream_if.sv
// ----------------------------------------------------------------------------
// jls_stream_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface jls_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/jacobi_linear_solver.sv
// ----------------------------------------------------------------------------
// jacobi_linear_solver: fixed-point jacobi solver with bit-serial arithmetic
// Loads an augmented matrix and runs jacobi sweeps on a solve item.
// ----------------------------------------------------------------------------
// Usage: req items with action write store one matrix entry (row, column,
// coefficient); column equal to unknowns_in_use holds the right-hand side.
// A solve item clears the solution, checks each diagonal entry and, unless one
// is zero, runs sweeps until every entry changes by no more than tolerance/65536
// times its old magnitude, or the iteration limit. Each row runs n-1 serial
// multiplies (read, load, 32 shift-add steps, accumulate), then row setup, the
// 64-step restoring divide and the update, and a sweep runs n rows; the single
// shift-add multiplier and the bit-serial divider set the rate.
// After the run one rsp item per unknown is emitted in order, one per cycle
// at best, with last on the final one. rsp holds its item while the receiver
// stalls; req is taken again once the final result sits in the output register.
// Reset (synchronous, active high) returns registers to 8, 100 and 66 and
// idles the sequencer; the matrix store is not cleared.
// ----------------------------------------------------------------------------
module jacobi_linear_solver #(
   parameter int FRACTION_BITS = jls_pkg::FractionBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   jls_stream_if.sink  req,
   jls_stream_if.source rsp,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import jls_pkg::*;

   localparam int MAX_UNKNOWNS = MaxUnknownsDefault;
   localparam int Cols  = MAX_UNKNOWNS + 1;
   localparam int Depth = MAX_UNKNOWNS * Cols;
   localparam int AW    = $clog2(Depth);
   localparam int UW    = $clog2(MAX_UNKNOWNS + 1);
   localparam int IW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
   localparam logic signed [63:0] AccLim = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] NumLim = 64'sd1 <<< (62 - FRACTION_BITS);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0, S_DIAG = 4'd1, S_DIAGW = 4'd2,
      S_ROW = 4'd3, S_RDA = 4'd4, S_MUL = 4'd5, S_ACC = 4'd6, S_RDB = 4'd7,
      S_NUM = 4'd8, S_DIV = 4'd9, S_FIN = 4'd10, S_SWEEP = 4'd11,
      S_OUT = 4'd12, S_RDD = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [UW-1:0] n_cfg_ff;
   logic [15:0] lim_ff, tol_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         n_cfg_ff <= UW'(8 > MAX_UNKNOWNS ? MAX_UNKNOWNS : 8);
         lim_ff   <= 16'd100;
         tol_ff   <= 16'd66;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UNKNOWNS: begin
               if (csr_data[3:0] == 4'd0) n_cfg_ff <= UW'(1);
               else if (32'(csr_data[3:0]) > MAX_UNKNOWNS) n_cfg_ff <= UW'(MAX_UNKNOWNS);
               else n_cfg_ff <= UW'(csr_data[3:0]);
            end
            CSR_ITER_LIM:  lim_ff <= csr_data;
            CSR_TOLERANCE: tol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // matrix memory, one port, registered read
   logic signed [31:0] mem [Depth];
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic signed [31:0] mem_q_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= req.payload.coefficient;
      mem_q_ff <= mem[mem_addr];
   end

   logic signed [31:0] xo_ff [MAX_UNKNOWNS];
   logic signed [31:0] xn_ff [MAX_UNKNOWNS];
   logic [IW-1:0] i_ff;
   logic [UW-1:0] j_ff;
   logic [IW-1:0] j_idx;
   logic [15:0]   sweep_ff;
   logic          conv_ff, zd_ff;
   logic signed [63:0] acc_ff;
   // serial multiplier
   logic [63:0]   prod_ff, mcand_ff;
   logic [31:0]   mplier_ff;
   logic          pneg_ff;
   logic [6:0]    cnt_ff;
   // serial divider
   logic [63:0]   dq_ff;
   logic [32:0]   drem_ff;
   logic [31:0]   dvs_ff;
   logic          qneg_ff;
   logic signed [63:0] numv;

   assign j_idx = IW'(j_ff);

   logic req_fire, rsp_fire;
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   logic [UW-1:0] n;
   assign n = n_cfg_ff;
   logic [IW-1:0] nm1;
   assign nm1 = IW'(n - UW'(1));

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [UW:0] c);
      return AW'(32'(r) * Cols + 32'(c));
   endfunction

   // memory address selection
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = '0;
      if (state_ff == S_IDLE) begin
         mem_we = req_fire && req.payload.action == ACT_WRITE
                  && 32'(req.payload.row) < MAX_UNKNOWNS
                  && 32'(req.payload.column) <= MAX_UNKNOWNS;
         mem_addr = AW'(32'(req.payload.row) * Cols + 32'(req.payload.column));
      end else if (state_ff == S_DIAG || state_ff == S_FIN)
         mem_addr = addr_of(i_ff, (UW+1)'(i_ff));
      else if (state_ff == S_RDD)
         mem_addr = addr_of(i_ff, (UW+1)'(j_ff));
      else if (state_ff == S_ACC || state_ff == S_RDB)
         mem_addr = addr_of(i_ff, (UW+1)'(n));
      else if (state_ff == S_NUM)
         mem_addr = addr_of(i_ff, (UW+1)'(i_ff));
   end

   // saturating accumulate of the signed product
   logic signed [63:0] sprod, acc_sum;
   logic signed [64:0] wide;
   assign sprod = pneg_ff ? -$signed(prod_ff) : $signed(prod_ff);
   assign wide  = 65'(acc_ff) + 65'(sprod);
   assign acc_sum = (wide > 65'(AccLim)) ? AccLim :
                    (wide < -65'(AccLim)) ? -AccLim : 64'(wide);

   // floor shift and clamped numerator
   logic signed [63:0] qfl;
   logic signed [64:0] nwide;
   assign qfl   = acc_ff >>> FRACTION_BITS;
   assign nwide = 65'(mem_q_ff) - 65'(qfl);
   assign numv  = (nwide > 65'(NumLim)) ? NumLim :
                  (nwide < -65'(NumLim)) ? -NumLim : 64'(nwide);

   // divider step
   logic [32:0] dtrial;
   logic [32:0] dshift;
   assign dshift = {drem_ff[31:0], dq_ff[63]};
   assign dtrial = dshift - {1'b0, dvs_ff};

   // saturated quotient
   logic signed [64:0] qs;
   logic signed [31:0] qsat;
   assign qs = qneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign qsat = (qs > 65'sd2147483647) ? 32'sh7fff_ffff :
                 (qs < -65'sd2147483648) ? 32'sh8000_0000 : 32'(qs);

   // convergence test on the new entry
   logic [32:0] dmag, omag;
   logic signed [32:0] dd;
   logic [48:0] lhs, rhs;
   logic        sweep_conv;
   assign dd   = 33'(qsat) - 33'(xo_ff[i_ff]);
   assign dmag = dd[32] ? 33'(-dd) : 33'(dd);
   assign omag = xo_ff[i_ff][31] ? 33'(-34'(xo_ff[i_ff])) : 33'(xo_ff[i_ff]);
   assign lhs  = {dmag, 16'd0};
   assign rhs  = 49'(omag) * 49'(tol_ff);
   assign sweep_conv = conv_ff && !(lhs > rhs);

   logic [15:0] lim_eff;
   assign lim_eff = (lim_ff == 16'd0) ? 16'd1 : lim_ff;

   rsp_type rsp_ff;
   logic    rsp_v_ff;
   logic    rsp_load;
   assign rsp.valid   = rsp_v_ff;
   assign rsp.payload = rsp_ff;
   assign rsp_load    = (state_ff == S_OUT) && (!rsp_v_ff || rsp_fire);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_v_ff <= 1'b1;
         else if (rsp_fire) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_fire && req.payload.action == ACT_SOLVE) begin
               for (int k = 0; k < MAX_UNKNOWNS; k++) begin
                  xo_ff[k] <= '0;
                  xn_ff[k] <= '0;
               end
               sweep_ff <= '0;
               i_ff <= '0;
               zd_ff <= 1'b0;
            end
            S_DIAGW: begin
               if (mem_q_ff == '0) zd_ff <= 1'b1;
               if (i_ff == nm1) begin
                  i_ff <= '0; conv_ff <= 1'b1;
               end else
                  i_ff <= i_ff + IW'(1);
            end
            S_ROW: begin
               acc_ff <= '0;
               j_ff <= '0;
            end
            S_RDD: begin
               // step over the diagonal entry
               if (j_ff < n && j_ff == UW'(i_ff)) j_ff <= j_ff + UW'(1);
            end
            S_RDA: begin
               pneg_ff   <= mem_q_ff[31] ^ xo_ff[j_idx][31];
               mcand_ff  <= {32'd0, (mem_q_ff[31] ? 32'(-33'(mem_q_ff)) : 32'(mem_q_ff))};
               mplier_ff <= xo_ff[j_idx][31] ? 32'(-33'(xo_ff[j_idx])) : 32'(xo_ff[j_idx]);
               prod_ff   <= '0;
               cnt_ff    <= '0;
            end
            S_MUL: begin
               if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff + 7'd1;
            end
            S_ACC: begin
               acc_ff <= acc_sum;
               j_ff   <= j_ff + UW'(1);
            end
            S_NUM: begin
               qneg_ff <= numv[63];
               dq_ff   <= 64'(numv[63] ? -numv : numv) << FRACTION_BITS;
               drem_ff <= '0;
               cnt_ff  <= '0;
            end
            S_FIN: begin
               // mem_q_ff holds the divisor here before S_DIV; see state_in
            end
            S_DIV: begin
               if (cnt_ff == 7'd0) begin
                  dvs_ff  <= mem_q_ff[31] ? 32'(-33'(mem_q_ff)) : 32'(mem_q_ff);
                  qneg_ff <= qneg_ff ^ mem_q_ff[31];
                  cnt_ff  <= 7'd1;
               end else begin
                  if (!dtrial[32]) begin
                     drem_ff <= dtrial;
                     dq_ff   <= {dq_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= dshift;
                     dq_ff   <= {dq_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            S_SWEEP: if (cnt_ff == 7'd65) begin
               xn_ff[i_ff] <= qsat;
               cnt_ff <= '0;
               // a new sweep starts out converged
               if (i_ff == nm1 && state_in == S_ROW) conv_ff <= 1'b1;
               else if (lhs > rhs) conv_ff <= 1'b0;
               if (i_ff == nm1) begin
                  for (int k = 0; k < MAX_UNKNOWNS; k++)
                     xo_ff[k] <= (k == int'(i_ff)) ? qsat : xn_ff[k];
                  sweep_ff <= sweep_ff + 16'd1;
                  i_ff <= '0;
               end else
                  i_ff <= i_ff + IW'(1);
            end
            S_OUT: if (rsp_load) begin
               rsp_ff.unknown_index <= 3'(i_ff);
               rsp_ff.solution      <= xn_ff[i_ff];
               rsp_ff.status        <= zd_ff ? ST_ZERO_DIAG :
                                       (conv_ff ? ST_CONVERGED : ST_LIMIT);
               rsp_ff.sweeps_done   <= sweep_ff;
               rsp_ff.last          <= (i_ff == nm1);
               i_ff <= i_ff + IW'(1);
            end
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire && req.payload.action == ACT_SOLVE) state_in = S_DIAG;
         S_DIAG:  state_in = S_DIAGW;
         S_DIAGW: if (i_ff == nm1) state_in = zd_ff || mem_q_ff == '0 ? S_OUT : S_ROW;
                  else state_in = S_DIAG;
         S_ROW:   state_in = S_RDD;
         S_RDD:   begin
            // skip the diagonal and finish the row at j == n
            if (j_ff >= n) state_in = S_RDB;
            else if (j_ff != UW'(i_ff)) state_in = S_RDA;
         end
         S_RDA:   state_in = S_MUL;
         S_MUL:   if (cnt_ff == 7'd31) state_in = S_ACC;
         S_ACC:   state_in = S_RDD;
         S_RDB:   state_in = S_NUM;
         S_NUM:   state_in = S_FIN;
         S_FIN:   state_in = S_DIV;
         S_DIV:   if (cnt_ff == 7'd64) state_in = S_SWEEP;
         S_SWEEP: if (cnt_ff == 7'd65) begin
            if (i_ff == nm1 && (sweep_conv || sweep_ff + 16'd1 >= lim_eff))
               state_in = S_OUT;
            else
               state_in = S_ROW;
         end
         S_OUT:   if (rsp_load && i_ff == nm1) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // result holds steady while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload));

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp.valid);

   // unknown count stays in range
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      n_cfg_ff >= UW'(1) && 32'(n_cfg_ff) <= MAX_UNKNOWNS);

   // sequencer only visits defined states
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= S_RDD);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the jacobi linear solver
// Loads augmented matrices and solve items, predicts every unknown's value,
// status and sweep count in fixed point and compares results in order.
// ----------------------------------------------------------------------------
module tb;
   import jls_pkg::*;

   localparam int          MaxN       = 8;
   localparam int          FracBits   = 16;
   localparam longint      AccLimit   = 64'sd1 <<< 62;
   localparam longint      NumLimit   = 64'sd1 <<< (62 - FracBits);
   localparam int unsigned CycleLimit = 3000000;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   jls_stream_if #(.payload_type(req_type)) req_if ();
   jls_stream_if #(.payload_type(rsp_type)) rsp_if ();

   jacobi_linear_solver u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow of the block's registers and matrix
   logic [3:0]         unknowns_reg;
   logic [15:0]        sweep_limit_reg;
   logic [15:0]        tolerance_reg;
   logic signed [31:0] coef_store [MaxN][MaxN+1];
   bit                 coef_written [MaxN][MaxN+1];

   rsp_type     expected_results [$];
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_left;
   bit          hold_armed;

   // clock and cycle limit
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result receiver: random stalls, one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_armed && rsp_if.valid) begin
         hold_armed = 1'b0;
         hold_left = 400;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %s: expected idx %0d sol %0d st %0d sw %0d last %0d",
                  what, want.unknown_index, want.solution, want.status,
                  want.sweeps_done, want.last);
         $display("   actual idx %0d sol %0d st %0d sw %0d last %0d",
                  got.unknown_index, got.solution, got.status, got.sweeps_done,
                  got.last);
      end
   endfunction

   // compare each delivered item with the oldest expectation
   always @(posedge clock) begin : check_result
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_results.size() == 0) begin
            want = '0;
            report_mismatch("unexpected item", want, got);
         end else begin
            want = expected_results.pop_front();
            if (got.unknown_index !== want.unknown_index || got.solution !== want.solution
                || got.status !== want.status || got.sweeps_done !== want.sweeps_done
                || got.last !== want.last)
               report_mismatch("field", want, got);
         end
      end
   end

   // one row of a jacobi sweep in fixed point
   function automatic logic signed [31:0] jacobi_row(int i, int n,
                                                     logic signed [31:0] x [MaxN]);
      longint acc;
      longint prod;
      longint num;
      longint quo;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         if (j != i) begin
            prod = longint'(coef_store[i][j]) * longint'(x[j]);
            if (prod > 0 && acc > AccLimit - prod) acc = AccLimit;
            else if (prod < 0 && acc < -AccLimit - prod) acc = -AccLimit;
            else acc = acc + prod;
         end
      end
      num = longint'(coef_store[i][n]) - (acc >>> FracBits);
      if (num > NumLimit) num = NumLimit;
      if (num < -NumLimit) num = -NumLimit;
      quo = (num <<< FracBits) / longint'(coef_store[i][i]);
      if (quo > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (quo < -64'sd2147483648) return 32'sh80000000;
      return quo[31:0];
   endfunction

   // whole solve: sweeps until converged or limit, then one result per unknown
   function automatic void predict_solve();
      int                 n;
      int unsigned        sweep_cap;
      int unsigned        sweeps;
      bit                 zero_diag;
      bit                 converged;
      logic signed [31:0] prev_x [MaxN];
      logic signed [31:0] next_x [MaxN];
      longint             diff;
      longint             bound;
      logic [1:0]         status;
      rsp_type            res;
      n = (unknowns_reg == 0) ? 1 : (unknowns_reg > MaxN) ? MaxN : int'(unknowns_reg);
      sweep_cap = (sweep_limit_reg == 0) ? 1 : sweep_limit_reg;
      for (int i = 0; i < MaxN; i++) begin
         prev_x[i] = '0;
         next_x[i] = '0;
      end
      sweeps = 0;
      zero_diag = 1'b0;
      converged = 1'b0;
      for (int i = 0; i < n; i++)
         if (coef_store[i][i] == 0) zero_diag = 1'b1;
      if (!zero_diag) begin
         while (!converged && sweeps < sweep_cap) begin
            converged = 1'b1;
            for (int i = 0; i < n; i++) begin
               next_x[i] = jacobi_row(i, n, prev_x);
               diff = longint'(next_x[i]) - longint'(prev_x[i]);
               if (diff < 0) diff = -diff;
               bound = longint'(prev_x[i]);
               if (bound < 0) bound = -bound;
               bound = bound * longint'(tolerance_reg);
               if ((diff <<< 16) > bound) converged = 1'b0;
            end
            prev_x = next_x;
            sweeps++;
         end
      end
      status = zero_diag ? ST_ZERO_DIAG : (converged ? ST_CONVERGED : ST_LIMIT);
      for (int i = 0; i < n; i++) begin
         res.unknown_index = i[2:0];
         res.solution      = next_x[i];
         res.status        = status;
         res.sweeps_done   = sweeps[15:0];
         res.last          = (i == n - 1);
         expected_results.push_back(res);
      end
   endfunction

   // offer one item, wait for acceptance, update the prediction
   task automatic send_item(logic action, logic [2:0] row, logic [3:0] column,
                            logic signed [31:0] coefficient);
      req_type item;
      item.action      = action;
      item.row         = row;
      item.column      = column;
      item.coefficient = coefficient;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (action == ACT_SOLVE) begin
         predict_solve();
      end else if (column <= MaxN) begin
         coef_store[row][column]   = coefficient;
         coef_written[row][column] = 1'b1;
      end
   endtask

   // stop offering and let the block drain before touching registers
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_UNKNOWNS:  unknowns_reg    = data[3:0];
         CSR_ITER_LIM:  sweep_limit_reg = data;
         CSR_TOLERANCE: tolerance_reg   = data;
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] off_diag_coef();
      return $signed($urandom_range(0, 131072)) - 32'sd65536;
   endfunction

   function automatic logic signed [31:0] diag_coef(int n);
      logic signed [31:0] v;
      v = (n + 1) * 65536 + $urandom_range(0, 65535);
      return $urandom_range(1) ? v : -v;
   endfunction

   // diagonally dominant system of n unknowns with random content
   task automatic load_system(int n);
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= n; c++)
            send_item(ACT_WRITE, r[2:0], c[3:0],
                      (c == r) ? diag_coef(n)
                      : (c == n) ? $signed($urandom_range(0, 2097152)) - 32'sd1048576
                      : off_diag_coef());
   endtask

   // make sure a solve never reads an entry that was never written
   task automatic fill_missing(int n);
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= n; c++)
            if (!coef_written[r][c])
               send_item(ACT_WRITE, r[2:0], c[3:0], (c == r) ? diag_coef(n) : off_diag_coef());
   endtask

   // zero on the diagonal: no sweep, every unknown flagged
   task automatic test_zero_diagonal();
      write_csr(CSR_UNKNOWNS, 16'd2);
      send_item(ACT_WRITE, 3'd0, 4'd0, 32'sh00010000);
      send_item(ACT_WRITE, 3'd0, 4'd1, 32'sh00008000);
      send_item(ACT_WRITE, 3'd0, 4'd2, 32'sh00030000);
      send_item(ACT_WRITE, 3'd1, 4'd0, 32'shFFFF0000);
      send_item(ACT_WRITE, 3'd1, 4'd1, 32'sh00000000);
      send_item(ACT_WRITE, 3'd1, 4'd2, 32'sh00020000);
      send_item(ACT_SOLVE, 3'd0, 4'd0, 32'sh0);
      wait_idle();
   endtask

   // one unknown: coefficient extremes, saturation, limit extremes
   task automatic test_single_unknown();
      write_csr(CSR_UNKNOWNS, 16'd1);
      write_csr(CSR_ITER_LIM, 16'hFFFF);
      write_csr(CSR_TOLERANCE, 16'hFFFF);
      send_item(ACT_WRITE, 3'd0, 4'd0, 32'sh7FFFFFFF);
      send_item(ACT_WRITE, 3'd0, 4'd1, 32'sh80000000);
      send_item(ACT_SOLVE, 3'd7, 4'd15, 32'shFFFFFFFF);
      send_item(ACT_WRITE, 3'd0, 4'd0, 32'sh00000001);
      send_item(ACT_WRITE, 3'd0, 4'd1, 32'sh7FFFFFFF);
      send_item(ACT_SOLVE, 3'd0, 4'd0, 32'sh0);
      wait_idle();
      // limit of zero still runs one sweep; zero tolerance
      write_csr(CSR_ITER_LIM, 16'd0);
      write_csr(CSR_TOLERANCE, 16'd0);
      send_item(ACT_WRITE, 3'd0, 4'd0, 32'sh80000000);
      send_item(ACT_SOLVE, 3'd0, 4'd0, 32'sh0);
      wait_idle();
   endtask

   // columns past the store are dropped; unknown count of zero acts as one
   task automatic test_ignored_writes();
      write_csr(CSR_UNKNOWNS, 16'd0);
      write_csr(CSR_ITER_LIM, 16'd20);
      write_csr(CSR_TOLERANCE, 16'd66);
      send_item(ACT_WRITE, 3'd0, 4'd9, 32'sh00000000);
      send_item(ACT_WRITE, 3'd7, 4'd15, 32'sh00000000);
      send_item(ACT_WRITE, 3'd0, 4'd0, 32'sh00020000);
      send_item(ACT_SOLVE, 3'd0, 4'd0, 32'sh0);
      wait_idle();
   endtask

   // full size system while the receiver holds off and the sender keeps offering
   task automatic test_backpressure();
      write_csr(CSR_UNKNOWNS, 16'd15);
      write_csr(CSR_ITER_LIM, 16'd2);
      write_csr(CSR_TOLERANCE, 16'($urandom_range(0, 65535)));
      load_system(MaxN);
      hold_armed <= 1'b1;
      send_item(ACT_SOLVE, 3'd0, 4'd0, 32'sh0);
      for (int k = 0; k < 3; k++)
         send_item(ACT_WRITE, 3'($urandom_range(0, 7)), 4'd8, $urandom);
      wait_idle();
   endtask

   // random systems and noise under three idling patterns
   task automatic test_random_traffic();
      int          start;
      int          n;
      int          pick;
      logic [3:0]  n_code;
      logic [15:0] tol;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 26 : 0;
         start = items_sent;
         while (items_sent - start < 6) begin
            wait_idle();
            n_code = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 4));
            n = (n_code == 0) ? 1 : (n_code > MaxN) ? MaxN : int'(n_code);
            pick = $urandom_range(3);
            tol = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            write_csr(CSR_UNKNOWNS, {12'd0, n_code});
            write_csr(CSR_ITER_LIM, 16'((n <= 4) ? $urandom_range(0, 20) : $urandom_range(0, 3)));
            write_csr(CSR_TOLERANCE, tol);
            if ($urandom_range(9) < 7) begin
               load_system(n);
            end else begin
               // noise: raw writes anywhere, then patch any unwritten entries
               repeat ($urandom_range(1, 4))
                  send_item(ACT_WRITE, 3'($urandom), 4'($urandom), $urandom);
               fill_missing(n);
            end
            send_item(ACT_SOLVE, 3'($urandom), 4'($urandom), $urandom);
         end
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_UNKNOWNS;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      hold_left = 0;
      hold_armed = 1'b0;
      mismatches = 0;
      items_sent = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      unknowns_reg = 4'd8;
      sweep_limit_reg = 16'd100;
      tolerance_reg = 16'd66;
      for (int r = 0; r < MaxN; r++)
         for (int c = 0; c <= MaxN; c++) begin
            coef_store[r][c] = '0;
            coef_written[r][c] = 1'b0;
         end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_diagonal();
      test_single_unknown();
      test_ignored_writes();
      test_backpressure();
      test_random_traffic();

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: jacobi_linear_solver.f
rtl/core/jls_pkg.sv
rtl/core/jls_stream_if.sv
rtl/core/jacobi_linear_solver.sv
tb/sv/tb.sv
